/* rtl/zbss_pkg.sv */
// ----------------------------------------------------------------------------
// zbss_pkg
// Shared widths, codes and controller/datapath signal groups for the zoned
// block to skewed sector mapper.
// ----------------------------------------------------------------------------
package zbss_pkg;

    localparam int TRACK_COUNT = 80;

    localparam int TRACK_W = 7;    // track number
    localparam int CNT_W   = 6;    // sectors per track, sector number
    localparam int BLK_W   = 13;   // logical block number
    localparam int DIV_W   = 15;   // dividend of the serial divider
    localparam int DVSR_W  = 7;    // divisor, up to twice the half count
    localparam int STEP_W  = 4;    // divider step counter

    localparam logic [TRACK_W-1:0] LAST_TRACK = TRACK_W'(TRACK_COUNT - 1);
    localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(DIV_W - 1);

    // action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_MAP  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load_wr;     // load word accepted
        logic map_start;   // map word accepted
        logic scan;        // walk the track table
        logic div1_init;   // offset / half
        logic div2_init;   // (2*offset + quotient) mod (2*half)
        logic div_step;    // one restoring step
        logic finish;      // form the result
        logic out_load;    // move result to the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;   // containing track found or table exhausted
    } sts_t;

endpackage

/* rtl/zbss_dp.sv */
// ----------------------------------------------------------------------------
// zbss_dp
// Datapath: track table memory, running-total scan, shared serial divider
// and result/output registers.
// ----------------------------------------------------------------------------
module zbss_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  zbss_pkg::cmd_t                 cmd,
    output zbss_pkg::sts_t                 sts,
    input  logic [zbss_pkg::TRACK_W-1:0]   track_index,
    input  logic [zbss_pkg::CNT_W-1:0]     sector_count,
    input  logic [zbss_pkg::BLK_W-1:0]     block_number,
    output logic [zbss_pkg::TRACK_W-1:0]   track,
    output logic [zbss_pkg::CNT_W-1:0]     sector,
    output logic                           error
);

    // track table
    logic [zbss_pkg::CNT_W-1:0]   spt_mem [zbss_pkg::TRACK_COUNT];
    logic [zbss_pkg::CNT_W-1:0]   rdata_reg;

    // scan
    logic [zbss_pkg::TRACK_W-1:0] addr_reg;
    logic [zbss_pkg::TRACK_W-1:0] trk_reg;
    logic                         rdv_reg;
    logic [zbss_pkg::BLK_W-1:0]   start_reg;
    logic [zbss_pkg::BLK_W-1:0]   blk_reg;
    logic [zbss_pkg::BLK_W-1:0]   next_sum;
    logic                         hit;
    logic                         last;
    logic                         done;

    // located track
    logic [zbss_pkg::TRACK_W-1:0] fnd_trk_reg;
    logic [zbss_pkg::CNT_W-1:0]   cnt_reg;
    logic [zbss_pkg::BLK_W-1:0]   off_reg;
    logic                         err_reg;
    logic [zbss_pkg::CNT_W-1:0]   half;
    logic                         half_zero;

    // serial divider
    logic [zbss_pkg::DIV_W-1:0]   dvd_reg;
    logic [zbss_pkg::CNT_W-1:0]   rem_reg;
    logic [zbss_pkg::DVSR_W-1:0]  dvsr_reg;
    logic [zbss_pkg::DVSR_W-1:0]  trial;
    logic                         ge;

    // result and output
    logic [zbss_pkg::TRACK_W-1:0] res_trk_reg;
    logic [zbss_pkg::CNT_W-1:0]   res_sec_reg;
    logic                         res_err_reg;
    logic [zbss_pkg::TRACK_W-1:0] out_trk_reg;
    logic [zbss_pkg::CNT_W-1:0]   out_sec_reg;
    logic                         out_err_reg;

    always_comb
    begin
        next_sum  = start_reg + zbss_pkg::BLK_W'(rdata_reg);
        hit       = blk_reg < next_sum;
        last      = trk_reg == zbss_pkg::LAST_TRACK;
        done      = rdv_reg && (hit || last);
        half      = zbss_pkg::CNT_W'((zbss_pkg::DVSR_W'(cnt_reg) + 7'd1) >> 1);
        half_zero = half == '0;
        trial     = {rem_reg, dvd_reg[zbss_pkg::DIV_W-1]};
        ge        = trial >= dvsr_reg;
    end

    assign sts.scan_done = done;

    // table memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && (track_index <= zbss_pkg::LAST_TRACK))
        begin
            spt_mem[track_index] <= sector_count;
        end
        rdata_reg <= spt_mem[addr_reg];
    end

    // read data valid flag of the scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdv_reg <= 1'b0;
        end
        else if (cmd.map_start)
        begin
            rdv_reg <= 1'b0;
        end
        else if (cmd.scan)
        begin
            rdv_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.map_start)
        begin
            addr_reg  <= '0;
            start_reg <= '0;
            blk_reg   <= block_number;
        end

        if (cmd.scan)
        begin
            addr_reg <= (addr_reg == zbss_pkg::LAST_TRACK) ? addr_reg
                                                           : addr_reg + 7'd1;
            trk_reg  <= addr_reg;
            if (done)
            begin
                // start stays at this track's start, also on the fallback
                fnd_trk_reg <= trk_reg;
                cnt_reg     <= rdata_reg;
                off_reg     <= blk_reg - start_reg;
                err_reg     <= !hit;
            end
            else if (rdv_reg)
            begin
                start_reg <= next_sum;
            end
        end

        if (cmd.div1_init)
        begin
            dvd_reg  <= zbss_pkg::DIV_W'(off_reg);
            rem_reg  <= '0;
            dvsr_reg <= zbss_pkg::DVSR_W'(half);
        end
        else if (cmd.div2_init)
        begin
            // quotient of the first pass sits in dvd_reg
            dvd_reg  <= zbss_pkg::DIV_W'({off_reg, 1'b0}) + dvd_reg;
            rem_reg  <= '0;
            dvsr_reg <= {half, 1'b0};
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? zbss_pkg::CNT_W'(trial - dvsr_reg)
                          : trial[zbss_pkg::CNT_W-1:0];
            dvd_reg <= {dvd_reg[zbss_pkg::DIV_W-2:0], ge};
        end

        if (cmd.load_wr)
        begin
            res_trk_reg <= '0;
            res_sec_reg <= '0;
            res_err_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            res_trk_reg <= fnd_trk_reg;
            res_sec_reg <= half_zero ? '0 : rem_reg;
            res_err_reg <= err_reg || half_zero;
        end

        if (cmd.out_load)
        begin
            out_trk_reg <= res_trk_reg;
            out_sec_reg <= res_sec_reg;
            out_err_reg <= res_err_reg;
        end
    end

    assign track  = out_trk_reg;
    assign sector = out_sec_reg;
    assign error  = out_err_reg;

endmodule

/* rtl/zbss_ctrl.sv */
// ----------------------------------------------------------------------------
// zbss_ctrl
// Controller: sequences accept, table scan, two divider passes and result
// hand-off; owns the input stall and output valid.
// ----------------------------------------------------------------------------
module zbss_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            action,
    input  logic            out_stall,
    output logic            in_stall,
    output logic            out_valid,
    output zbss_pkg::cmd_t  cmd,
    input  zbss_pkg::sts_t  sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PREP,
        S_DIV1,
        S_MID,
        S_DIV2,
        S_FIN,
        S_DONE
    } state_t;

    state_t                      state_reg;
    logic [zbss_pkg::STEP_W-1:0] step_reg;
    logic                        in_stall_reg;
    logic                        out_valid_reg;
    logic                        accept;

    always_comb
    begin
        accept        = in_valid && !in_stall_reg;
        cmd.load_wr   = accept && (action == zbss_pkg::ACT_LOAD);
        cmd.map_start = accept && (action == zbss_pkg::ACT_MAP);
        cmd.scan      = state_reg == S_SCAN;
        cmd.div1_init = state_reg == S_PREP;
        cmd.div2_init = state_reg == S_MID;
        cmd.div_step  = (state_reg == S_DIV1) || (state_reg == S_DIV2);
        cmd.finish    = state_reg == S_FIN;
        cmd.out_load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            in_stall_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result taking the slot keeps valid up
            if (out_valid_reg && !out_stall && !cmd.out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        in_stall_reg <= 1'b1;
                        state_reg    <= (action == zbss_pkg::ACT_MAP) ? S_SCAN : S_DONE;
                    end
                end
                S_SCAN:
                begin
                    if (sts.scan_done)
                    begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    step_reg  <= '0;
                    state_reg <= S_DIV1;
                end
                S_DIV1:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == zbss_pkg::LAST_STEP)
                    begin
                        state_reg <= S_MID;
                    end
                end
                S_MID:
                begin
                    step_reg  <= '0;
                    state_reg <= S_DIV2;
                end
                S_DIV2:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == zbss_pkg::LAST_STEP)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (cmd.out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        in_stall_reg  <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = in_stall_reg;
    assign out_valid = out_valid_reg;

endmodule

/* rtl/zoned_block_to_skewed_sector.sv */
// ----------------------------------------------------------------------------
// zoned_block_to_skewed_sector
// Maps a logical block of a zoned floppy to a track and a skew-of-two sector,
// from a table of sectors per track loaded beforehand.
// ----------------------------------------------------------------------------
// One word in, one word out. A load word (action 0) writes one entry of the
// 80-entry sectors-per-track table (indexes past the last track are dropped)
// and answers with an all-zero word. A map word (action 1) walks the table
// from track 0, one entry per cycle through the table memory's registered
// read port, keeping a running total until the total passes the block; if it
// never does, the last track is reported with error set. The offset inside
// the track is then skewed by a shared restoring divider, one bit per cycle,
// run twice (offset / half, then the mod by 2*half). A map word takes longer
// the higher its track, as the scan walks the table from track 0. The block
// works on one word at a time: in_stall is high from acceptance until the
// result moves into the output register, which holds it while out_stall is
// high, so the next word may be taken while the previous result still waits.
// A map of a block whose scan reads a table entry never loaded since reset
// gives meaningless fields.
// ----------------------------------------------------------------------------
module zoned_block_to_skewed_sector (
    input  logic                           clk,
    input  logic                           rst_n,
    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           action,
    input  logic [zbss_pkg::TRACK_W-1:0]   track_index,
    input  logic [zbss_pkg::CNT_W-1:0]     sector_count,
    input  logic [zbss_pkg::BLK_W-1:0]     block_number,
    // output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [zbss_pkg::TRACK_W-1:0]   track,
    output logic [zbss_pkg::CNT_W-1:0]     sector,
    output logic                           error
);

    zbss_pkg::cmd_t cmd;   // sequencing commands
    zbss_pkg::sts_t sts;   // scan status back to the controller

    // state machine: accept, scan, two divider passes, hand-off
    zbss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .action    (action),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd),
        .sts       (sts)
    );

    // table memory, scan accumulator, divider, result registers
    zbss_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .track_index  (track_index),
        .sector_count (sector_count),
        .block_number (block_number),
        .track        (track),
        .sector       (sector),
        .error        (error)
    );

    // scan and divider only run for a word in flight
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan || cmd.div_step || cmd.finish) |-> in_stall)
        else $error("datapath busy while input open");

    // an accepted word closes the input until its result is handed off
    a_accept_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input still open after accept");

    // a result hand-off always shows up as a valid output word
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (out_valid && !in_stall))
        else $error("result loaded but not presented");

endmodule
